// ----- sv/blrls_pkg.sv -----
// shared types and constants for the bilevel line run-length segmenter
// no dependencies; imported by blrls_front, blrls_back and the top level
package blrls_pkg;

  localparam int MAX_LINE_BYTES = 4096;
  localparam int CNT_W          = 16;
  localparam logic [CNT_W-1:0] RUN_LIMIT = CNT_W'(MAX_LINE_BYTES * 8);
  localparam logic [CNT_W-1:0] CAP_RESET = '1;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // one raster byte after classification
  typedef struct packed {
    logic [7:0] pix;
    logic       eol;
    logic       start;
    logic [6:0] rise_int;   // black pixel whose left neighbour in the byte is white
    logic       blank;      // all eight pixels white
  } item_t;

  // one run-length result
  typedef struct packed {
    logic [CNT_W-1:0] black;
    logic [CNT_W-1:0] white;
    logic             delim;
    logic             ovf;
    logic             last;
  } res_t;

endpackage

// ----- sv/blrls_front.sv -----
// front end: takes raster bytes, marks black-run starts inside the byte, queues them
// depends on blrls_pkg
module blrls_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          raster_byte_i,
  input  logic                last_in_line_i,
  input  logic                image_start_i,
  output logic                head_valid_o,
  output blrls_pkg::item_t    head_o,
  input  logic                pop_i
);
  import blrls_pkg::*;

  item_t               mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]     cnt_q, cnt_d;
  item_t               cls;
  logic                push;
  logic                pull;

  always_comb begin
    cls          = '0;
    cls.pix      = raster_byte_i;
    cls.eol      = last_in_line_i;
    cls.start    = image_start_i;
    cls.blank    = (raster_byte_i == 8'h00);
    for (int i = 0; i < 7; i++) begin
      cls.rise_int[i] = raster_byte_i[i] & ~raster_byte_i[i+1];
    end
  end

  assign in_ready_o   = (cnt_q != (QPTR_W+1)'(QUEUE_DEPTH));
  assign push         = in_valid_i & in_ready_o;
  assign head_valid_o = (cnt_q != '0);
  assign pull         = pop_i & head_valid_o;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pull) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pull) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pull && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- sv/blrls_back.sv -----
// back end: walks one queued byte run by run, keeps the line and image state,
// and holds the result register; depends on blrls_pkg
module blrls_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [blrls_pkg::CNT_W-1:0] cap_i,
  input  logic                        head_valid_i,
  input  blrls_pkg::item_t            head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output blrls_pkg::res_t             res_o
);
  import blrls_pkg::*;

  localparam logic [1:0] PH_FIRST  = 2'd0;
  localparam logic [1:0] PH_DECIDE = 2'd1;
  localparam logic [1:0] PH_WALK   = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [7:0]       rem_q, rem_d;
  logic             prev_q, prev_d;
  logic [CNT_W-1:0] black_q, black_d;
  logic [CNT_W-1:0] white_q, white_d;
  logic [CNT_W-1:0] used_q, used_d;
  logic             drop_q, drop_d;
  logic             out_valid_q;
  res_t             out_q;

  logic             o_free;
  logic             adv;
  logic             walk;
  logic             emit;
  res_t             res_d;
  logic [7:0]       rem;
  logic [7:0]       rise;
  logic [7:0]       rr;
  logic [2:0]       p;
  logic             has_rise;
  logic [7:0]       le_mask;
  logic [7:0]       lo_mask;
  logic [7:0]       seg;
  logic [3:0]       k1;
  logic [3:0]       k0;
  logic [CNT_W:0]   black_sum;
  logic [CNT_W:0]   white_sum;
  logic [CNT_W-1:0] black_n;
  logic [CNT_W-1:0] white_n;
  logic             prev_eff;
  logic             more;
  logic [CNT_W-1:0] used_inc;

  assign o_free = ~out_valid_q | out_ready_i;
  assign adv    = head_valid_i & o_free;

  // segment from the current position down to the next black-run start
  assign rem  = (phase_q == PH_WALK) ? rem_q : 8'hFF;
  assign rise = {head_i.pix[7] & ~prev_q, head_i.rise_int};
  assign rr   = rise & rem;

  always_comb begin
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (rr[i]) begin
        p = 3'(i);
      end
    end
  end

  assign has_rise = |rr;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      le_mask[i] = (3'(i) <= p);
      lo_mask[i] = (3'(i) < p);
    end
  end

  // pixels before the run start: some black, then some white
  assign seg       = has_rise ? (rem & ~le_mask) : rem;
  assign k1        = 4'($countones(seg & head_i.pix));
  assign k0        = 4'($countones(seg & ~head_i.pix));
  assign black_sum = {1'b0, black_q} + (CNT_W+1)'(k1);
  assign white_sum = {1'b0, white_q} + (CNT_W+1)'(k0);
  assign black_n   = (black_sum > {1'b0, RUN_LIMIT}) ? RUN_LIMIT : black_sum[CNT_W-1:0];
  assign prev_eff  = (k1 != '0) | prev_q;

  always_comb begin
    if (k0 == '0) begin
      white_n = white_q;
    end else if (prev_eff) begin
      white_n = CNT_W'(k0);
    end else if (white_sum > {1'b0, RUN_LIMIT}) begin
      white_n = RUN_LIMIT;
    end else begin
      white_n = white_sum[CNT_W-1:0];
    end
  end

  assign more     = |(rise & lo_mask);
  assign used_inc = (used_q == '1) ? used_q : used_q + 1'b1;

  always_comb begin
    phase_d = phase_q;
    rem_d   = rem_q;
    prev_d  = prev_q;
    black_d = black_q;
    white_d = white_q;
    used_d  = used_q;
    drop_d  = drop_q;
    emit    = 1'b0;
    res_d   = '0;
    pop_o   = 1'b0;
    walk    = 1'b0;
    if (adv) begin
      if (phase_q == PH_WALK) begin
        walk = 1'b1;
      end else if (phase_q == PH_FIRST && head_i.start) begin
        // header entry; nothing follows when the byte is blank, not a line end
        // and the count leaves room
        emit       = 1'b1;
        res_d.delim = 1'b1;
        res_d.last = (cap_i > CNT_W'(1)) & head_i.blank & ~head_i.eol;
        used_d     = CNT_W'(1);
        drop_d     = 1'b0;
        black_d    = '0;
        white_d    = '0;
        prev_d     = 1'b0;
        phase_d    = PH_DECIDE;
      end else if (drop_q) begin
        if (head_i.eol) begin
          drop_d  = 1'b0;
          black_d = '0;
          white_d = '0;
          prev_d  = 1'b0;
        end
        pop_o   = 1'b1;
        phase_d = PH_FIRST;
      end else if (used_q >= cap_i) begin
        emit       = 1'b1;
        res_d.ovf  = 1'b1;
        res_d.last = 1'b1;
        black_d    = '0;
        white_d    = '0;
        prev_d     = 1'b0;
        drop_d     = ~head_i.eol;
        pop_o      = 1'b1;
        phase_d    = PH_FIRST;
      end else begin
        walk = 1'b1;
      end

      if (walk) begin
        if (has_rise) begin
          emit        = 1'b1;
          res_d.black = black_n;
          res_d.white = white_n;
          res_d.last  = ~more & ~head_i.eol;
          used_d      = used_inc;
          black_d     = CNT_W'(1);
          white_d     = '0;
          prev_d      = 1'b1;
          rem_d       = rem & lo_mask;
          phase_d     = PH_WALK;
        end else begin
          black_d = black_n;
          white_d = white_n;
          if (|rem) begin
            prev_d = head_i.pix[0];
          end
          if (head_i.eol) begin
            emit        = 1'b1;
            res_d.black = black_n;
            res_d.delim = 1'b1;
            res_d.last  = 1'b1;
            used_d      = used_inc;
            black_d     = '0;
            white_d     = '0;
            prev_d      = 1'b0;
          end
          pop_o   = 1'b1;
          phase_d = PH_FIRST;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      rem_q       <= '0;
      prev_q      <= 1'b0;
      black_q     <= '0;
      white_q     <= '0;
      used_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      rem_q   <= rem_d;
      prev_q  <= prev_d;
      black_q <= black_d;
      white_q <= white_d;
      used_q  <= used_d;
      drop_q  <= drop_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = out_q;

`ifndef ASSERT_OFF
  a_item_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_FIRST |-> head_valid_i)
    else $error("byte left the queue before its walk finished");

  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_o.ovf |-> res_o.black == '0 && res_o.white == '0 && !res_o.delim)
    else $error("overflow result carries run data");

  a_delim_white: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_o.delim |-> res_o.white == '0)
    else $error("delimiter entry with a white length");

  a_run_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    black_q > RUN_LIMIT || white_q > RUN_LIMIT |-> 1'b0)
    else $error("run count beyond saturation limit");
`endif

endmodule

// ----- sv/bilevel_line_run_length_segmenter.sv -----
// bilevel line run-length segmenter, top level: capacity register and field mapping
// depends on blrls_pkg, blrls_front, blrls_back
//
// Input channel (in_valid_i/in_ready_o) carries one packed raster byte, MSB first,
// 1 = black, with line-end and image-start flags. Output channel
// (out_valid_o/out_ready_i) carries run-length entries: black run, following white
// run, delimiter for line ends and image headers, overflow when the entry capacity
// is used up; last_result_o marks the final result of a byte.
// The configuration channel writes entry_capacity (reset 65535); cfg_ready_o is
// always high and writes belong in idle periods.
// A transfer on the input lands in a two-entry queue; with the back end idle the
// byte goes from the queue register to the back end, which writes its first result
// into the result register. The back end walks a byte in steps: one per header entry,
// one per black run starting in the byte and one closing step (which also emits the
// line-end entry); bytes that overflow or are dropped are popped without a walk.
// A stalled receiver holds the result register and the back end; the queue keeps
// taking bytes until it is full. Reset empties the queue and clears the run counts,
// the entry count, the drop flag and the result valid flag.
module bilevel_line_run_length_segmenter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  raster_byte_i,
  input  logic        last_in_line_i,
  input  logic        image_start_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] black_length_o,
  output logic [15:0] white_length_o,
  output logic        delimiter_o,
  output logic        overflow_o,
  output logic        last_result_o
);
  import blrls_pkg::*;

  logic [CNT_W-1:0] cap_q;
  logic             head_valid;
  item_t            head;
  logic             pop;
  res_t             res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  blrls_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .raster_byte_i  (raster_byte_i),
    .last_in_line_i (last_in_line_i),
    .image_start_i  (image_start_i),
    .head_valid_o   (head_valid),
    .head_o         (head),
    .pop_i          (pop)
  );

  blrls_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cap_i        (cap_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign black_length_o = res.black;
  assign white_length_o = res.white;
  assign delimiter_o    = res.delim;
  assign overflow_o     = res.ovf;
  assign last_result_o  = res.last;

endmodule
